// ===== design/bss_pkg.sv =====
// ----------------------------------------------------------------------------
// bss_pkg: shared types and constants for the buffer size search sequencer
// Phase codes, stream codes, register indexes, golden-section constants and
// the probe mixing and rounding functions.
// ----------------------------------------------------------------------------
`default_nettype none

package bss_pkg;

  // Field and port widths
  localparam int SIZE_W    = 33;  // interval ends and probes
  localparam int BUF_W     = 32;  // buffer_size field
  localparam int READS_W   = 16;  // reads_per_probe field
  localparam int LAT_W_DEF = 32;  // default compared latency width
  localparam int CFG_AW    = 4;
  localparam int CFG_DW    = 32;
  localparam int OUT_DW    = BUF_W + READS_W;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_DOUBLE = 2'd1,
    PH_GOLDEN = 2'd2
  } phase_t;

  localparam logic ACT_START   = 1'b0;
  localparam logic ACT_MEASURE = 1'b1;
  localparam logic KIND_PROBE  = 1'b0;
  localparam logic KIND_FINAL  = 1'b1;

  localparam logic [1:0] REG_BASE_LOG2  = 2'd0;
  localparam logic [1:0] REG_MAX_SHIFT  = 2'd1;
  localparam logic [1:0] REG_FULL_READS = 2'd2;

  localparam logic [4:0]  BASE_LOG2_RST  = 5'd9;
  localparam logic [3:0]  MAX_SHIFT_RST  = 4'd8;
  localparam logic [15:0] FULL_READS_RST = 16'd1000;

  localparam logic [4:0]  UNIT_LOG_MIN = 5'd9;
  localparam logic [4:0]  UNIT_LOG_MAX = 5'd16;
  localparam logic [15:0] DOUBLING_READS_CAP = 16'd300;

  // Q0.16 golden ratios (GOLD_BIG truncated; the two sum to 1.0)
  localparam logic [15:0] GOLD_BIG   = 16'd40503;
  localparam logic [15:0] GOLD_SMALL = 16'd25033;

  // Clamp the base log2 into its legal range
  function automatic logic [4:0] unit_log(input logic [4:0] base_log2);
    logic [4:0] v;
    v = base_log2;
    if (v < UNIT_LOG_MIN) v = UNIT_LOG_MIN;
    if (v > UNIT_LOG_MAX) v = UNIT_LOG_MAX;
    return v;
  endfunction

  // Round down to a multiple of the base size
  function automatic logic [SIZE_W-1:0] round_unit(input logic [SIZE_W-1:0] x,
                                                   input logic [4:0] ul);
    logic [SIZE_W-1:0] low_mask;
    low_mask = (SIZE_W'(1) << ul) - SIZE_W'(1);
    return x & ~low_mask;
  endfunction

  // (GOLD_BIG*x_big + GOLD_SMALL*x_small) >> 16, rounded to the base
  function automatic logic [SIZE_W-1:0] gold_mix(input logic [SIZE_W-1:0] x_big,
                                                 input logic [SIZE_W-1:0] x_small,
                                                 input logic [4:0] ul);
    logic [SIZE_W+15:0] acc;
    acc = (SIZE_W+16)'(GOLD_BIG) * (SIZE_W+16)'(x_big)
        + (SIZE_W+16)'(GOLD_SMALL) * (SIZE_W+16)'(x_small);
    return round_unit(acc[SIZE_W+15:16], ul);
  endfunction

endpackage

`default_nettype wire

// ===== design/buffer_size_search_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// buffer_size_search_sequencer_core: lowest-latency buffer size search
// Doubles the probe size from the base while latency does not rise, then
// runs a golden-section search on the bracketing interval and answers with
// its rounded midpoint, or, if doubling reaches max_shift, with the last probe.
// ----------------------------------------------------------------------------
//
//  Channel | Ports                          | Beat contents
//  --------+--------------------------------+----------------------------------
//  in      | in_tvalid/in_tready            | tuser: action, tdata: latency
//  out     | out_tvalid/out_tready          | tuser: kind,
//          |                                | tdata: buffer_size, reads_per_probe
//  cfg     | cfg_psel/penable/pwrite/pready | base_size_log2, max_shift,
//          |                                | full_reads at 0x0, 0x4, 0x8
//
//  The search state and the result register are updated at the edge that
//  accepts an input beat, so a new beat can be taken every cycle while the
//  result register can take it. The result register holds one result beat;
//  input is stalled only while that register is full and out_tready is low.
//  A measurement beat while idle produces no output beat. rst_n (synchronous)
//  resets the configuration and search registers and sets the search to idle.
//
`default_nettype none

module buffer_size_search_sequencer_core #(
  parameter int LATENCY_WIDTH = bss_pkg::LAT_W_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // input stream
  input  wire logic                         in_tvalid,
  output      logic                         in_tready,
  input  wire logic [bss_pkg::BUF_W-1:0]    in_tdata,   // [31:0] latency
  input  wire logic                         in_tuser,   // [0] action
  // result stream
  output      logic                         out_tvalid,
  input  wire logic                         out_tready,
  output      logic [bss_pkg::OUT_DW-1:0]   out_tdata,  // [31:0] buffer_size,
                                                        // [47:32] reads_per_probe
  output      logic                         out_tuser,  // [0] kind
  // configuration
  input  wire logic                         cfg_psel,
  input  wire logic                         cfg_penable,
  input  wire logic                         cfg_pwrite,
  input  wire logic [bss_pkg::CFG_AW-1:0]   cfg_paddr,
  input  wire logic [bss_pkg::CFG_DW-1:0]   cfg_pwdata,
  output      logic [bss_pkg::CFG_DW-1:0]   cfg_prdata,
  output      logic                         cfg_pready
);

  import bss_pkg::*;

  // Latency is compared on at most the width of the field
  localparam int LW = (LATENCY_WIDTH < BUF_W) ? LATENCY_WIDTH : BUF_W;

  // Configuration registers
  logic [4:0]         base_log2_r;
  logic [3:0]         max_shift_r;
  logic [READS_W-1:0] full_reads_r;

  // Search state
  phase_t             phase_r, phase_nxt;
  logic [4:0]         shift_count_r, shift_count_nxt;
  logic [LW-1:0]      best_lat_r, best_lat_nxt;
  logic               best_valid_r, best_valid_nxt;
  logic [SIZE_W-1:0]  low_end_r, low_end_nxt;
  logic [SIZE_W-1:0]  high_end_r, high_end_nxt;
  logic [SIZE_W-1:0]  probe_left_r, probe_left_nxt;
  logic [SIZE_W-1:0]  probe_right_r, probe_right_nxt;
  logic [LW-1:0]      lat_left_r, lat_left_nxt;
  logic [LW-1:0]      lat_right_r, lat_right_nxt;
  logic               need_left_r, need_left_nxt;
  logic               need_right_r, need_right_nxt;

  // Result register
  logic               out_valid_r;
  logic               out_kind_r, out_kind_nxt;
  logic [BUF_W-1:0]   out_size_r;
  logic [READS_W-1:0] out_reads_r, out_reads_nxt;
  logic [SIZE_W-1:0]  res_size;
  logic               res_valid;

  logic               in_fire;
  logic               cfg_wr;
  logic [1:0]         cfg_idx;
  logic [4:0]         ul;
  logic [LW-1:0]      lat;
  logic [READS_W-1:0] dbl_reads;
  logic               lat_keep;
  logic               golden_entry;
  logic [4:0]         low_shift;
  logic [4:0]         shift_inc;
  logic [SIZE_W-1:0]  entry_low, entry_high;
  logic [SIZE_W-1:0]  ml_a, ml_b, mr_a, mr_b;
  logic [SIZE_W-1:0]  mix_left, mix_right;

  assign in_fire   = in_tvalid && in_tready;
  assign in_tready = !out_valid_r || out_tready;
  assign cfg_wr    = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx   = cfg_paddr[3:2];
  assign cfg_pready = 1'b1;

  assign ul        = unit_log(base_log2_r);
  assign lat       = in_tdata[LW-1:0];
  assign dbl_reads = (full_reads_r < DOUBLING_READS_CAP) ? full_reads_r
                                                         : DOUBLING_READS_CAP;

  // A measurement above the best so far ends the doubling run
  assign lat_keep     = !best_valid_r || (lat <= best_lat_r);
  assign golden_entry = (phase_r == PH_DOUBLE) && (in_tuser == ACT_MEASURE)
                        && !lat_keep;

  // Bracket: base << max(0, s-3) .. base << (s+1)
  assign shift_inc  = shift_count_r + 5'd1;
  assign low_shift  = (shift_count_r > 5'd3) ? (shift_count_r - 5'd3) : 5'd0;
  assign entry_low  = SIZE_W'(1) << ({1'b0, ul} + {2'b00, low_shift[3:0]});
  assign entry_high = SIZE_W'(1) << ({1'b0, ul} + {1'b0, shift_inc});

  // One mixer per side, shared between interval entry and the golden step
  assign ml_a = golden_entry ? entry_low  : low_end_r;
  assign ml_b = golden_entry ? entry_high : probe_right_r;
  assign mr_a = golden_entry ? entry_low  : probe_left_r;
  assign mr_b = golden_entry ? entry_high : high_end_r;
  assign mix_left  = gold_mix(ml_a, ml_b, ul);
  assign mix_right = gold_mix(mr_b, mr_a, ul);

  always_comb begin
    logic             do_next;
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] eps;
    logic [SIZE_W:0]   mid_sum;

    phase_nxt       = phase_r;
    shift_count_nxt = shift_count_r;
    best_lat_nxt    = best_lat_r;
    best_valid_nxt  = best_valid_r;
    low_end_nxt     = low_end_r;
    high_end_nxt    = high_end_r;
    probe_left_nxt  = probe_left_r;
    probe_right_nxt = probe_right_r;
    lat_left_nxt    = lat_left_r;
    lat_right_nxt   = lat_right_r;
    need_left_nxt   = need_left_r;
    need_right_nxt  = need_right_r;
    res_valid       = 1'b0;
    out_kind_nxt    = KIND_PROBE;
    res_size        = '0;
    out_reads_nxt   = '0;
    do_next         = 1'b0;

    if (in_fire) begin
      if (in_tuser == ACT_START) begin
        // Drop any running search and ask for the base size
        phase_nxt       = PH_DOUBLE;
        shift_count_nxt = 5'd0;
        best_valid_nxt  = 1'b0;
        best_lat_nxt    = '0;
        need_left_nxt   = 1'b0;
        need_right_nxt  = 1'b0;
        res_valid       = 1'b1;
        res_size        = SIZE_W'(1) << ul;
        out_reads_nxt   = dbl_reads;
      end else begin
        case (phase_r)
          PH_DOUBLE: begin
            if (lat_keep) begin
              best_lat_nxt    = lat;
              best_valid_nxt  = 1'b1;
              shift_count_nxt = shift_inc;
              res_valid       = 1'b1;
              if ({1'b0, shift_count_r} + 6'd1 > {2'b00, max_shift_r}) begin
                phase_nxt    = PH_IDLE;
                out_kind_nxt = KIND_FINAL;
                res_size     = SIZE_W'(1) << ({1'b0, ul} + {2'b00, shift_count_r[3:0]});
              end else begin
                res_size      = SIZE_W'(1) << ({1'b0, ul} + {2'b00, shift_inc[3:0]});
                out_reads_nxt = dbl_reads;
              end
            end else begin
              low_end_nxt     = entry_low;
              high_end_nxt    = entry_high;
              probe_left_nxt  = mix_left;
              probe_right_nxt = mix_right;
              need_left_nxt   = 1'b1;
              need_right_nxt  = 1'b1;
              phase_nxt       = PH_GOLDEN;
              do_next         = 1'b1;
            end
          end
          PH_GOLDEN: begin
            // Capture the measurement for whichever probe was outstanding
            if (need_left_r) begin
              lat_left_nxt  = lat;
              need_left_nxt = 1'b0;
            end else if (need_right_r) begin
              lat_right_nxt  = lat;
              need_right_nxt = 1'b0;
            end
            if (need_right_nxt) begin
              res_valid     = 1'b1;
              res_size      = probe_right_r;
              out_reads_nxt = full_reads_r;
            end else if (lat_left_nxt < lat_right_nxt) begin
              high_end_nxt    = probe_right_r;
              probe_right_nxt = probe_left_r;
              lat_right_nxt   = lat_left_nxt;
              probe_left_nxt  = mix_left;
              need_left_nxt   = 1'b1;
              do_next         = 1'b1;
            end else begin
              low_end_nxt     = probe_left_r;
              probe_left_nxt  = probe_right_r;
              lat_left_nxt    = lat_right_nxt;
              probe_right_nxt = mix_right;
              need_right_nxt  = 1'b1;
              do_next         = 1'b1;
            end
          end
          default: begin
            // Idle: drop the measurement
          end
        endcase
      end
    end

    // Golden-section continue-or-stop decision on the updated interval
    width   = (high_end_nxt > low_end_nxt) ? (high_end_nxt - low_end_nxt) : '0;
    eps     = SIZE_W'(3) << ul;
    mid_sum = {1'b0, low_end_nxt} + {1'b0, high_end_nxt};
    if (do_next) begin
      res_valid = 1'b1;
      if ((width > eps) && (probe_left_nxt != probe_right_nxt)) begin
        res_size      = need_left_nxt ? probe_left_nxt : probe_right_nxt;
        out_reads_nxt = full_reads_r;
      end else begin
        phase_nxt    = PH_IDLE;
        out_kind_nxt = KIND_FINAL;
        res_size     = round_unit(mid_sum[SIZE_W:1], ul);
      end
    end
  end

  // Search state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_log2_r   <= BASE_LOG2_RST;
      max_shift_r   <= MAX_SHIFT_RST;
      full_reads_r  <= FULL_READS_RST;
      phase_r       <= PH_IDLE;
      shift_count_r <= '0;
      best_lat_r    <= '0;
      best_valid_r  <= 1'b0;
      low_end_r     <= '0;
      high_end_r    <= '0;
      probe_left_r  <= '0;
      probe_right_r <= '0;
      lat_left_r    <= '0;
      lat_right_r   <= '0;
      need_left_r   <= 1'b0;
      need_right_r  <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (cfg_idx)
          REG_BASE_LOG2:  base_log2_r  <= cfg_pwdata[4:0];
          REG_MAX_SHIFT:  max_shift_r  <= cfg_pwdata[3:0];
          REG_FULL_READS: full_reads_r <= cfg_pwdata[READS_W-1:0];
          default: begin
          end
        endcase
      end
      phase_r       <= phase_nxt;
      shift_count_r <= shift_count_nxt;
      best_lat_r    <= best_lat_nxt;
      best_valid_r  <= best_valid_nxt;
      low_end_r     <= low_end_nxt;
      high_end_r    <= high_end_nxt;
      probe_left_r  <= probe_left_nxt;
      probe_right_r <= probe_right_nxt;
      lat_left_r    <= lat_left_nxt;
      lat_right_r   <= lat_right_nxt;
      need_left_r   <= need_left_nxt;
      need_right_r  <= need_right_nxt;
    end
  end

  // Result register: load on every accepted beat, clear when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= res_valid;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_kind_r  <= out_kind_nxt;
      out_size_r  <= res_size[BUF_W-1:0];
      out_reads_r <= out_reads_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {out_reads_r, out_size_r};

  // Register readback
  always_comb begin
    case (cfg_idx)
      REG_BASE_LOG2:  cfg_prdata = CFG_DW'(base_log2_r);
      REG_MAX_SHIFT:  cfg_prdata = CFG_DW'(max_shift_r);
      REG_FULL_READS: cfg_prdata = CFG_DW'(full_reads_r);
      default:        cfg_prdata = '0;
    endcase
  end

`ifndef ASSERT_OFF
  // A start beat always produces a probe request
  a_start_probe: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_tuser == ACT_START) |=> out_tvalid && (out_tuser == KIND_PROBE))
    else $error("start beat did not produce a probe request");

  // A measurement while idle produces no result
  a_idle_drop: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_tuser == ACT_MEASURE) && (phase_r == PH_IDLE) |=> !out_tvalid)
    else $error("measurement while idle produced a result");

  // Doubling never runs past the largest shift
  a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DOUBLE) |-> (shift_count_r[4] == 1'b0))
    else $error("doubling shift count out of range");

  // Golden phase always waits for at least one probe
  a_golden_need: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_GOLDEN) |-> (need_left_r || need_right_r))
    else $error("golden phase with no outstanding probe");

  // Final answers carry no read count
  a_final_reads: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_FINAL) |-> (out_tdata[47:32] == 16'd0))
    else $error("final answer with nonzero read count");
`endif

endmodule

`default_nettype wire
